// File: sv/bwd_pkg.sv
`default_nettype none

package bwd_pkg;

    localparam int COUNT_W = 32;
    localparam int LIMIT_W = 21;
    localparam int PERIOD_W = 16;

    localparam logic [COUNT_W-1:0] SHORT_TIMEOUT_RST = 32'd600000;
    localparam logic [COUNT_W-1:0] LONG_TIMEOUT_RST = 32'd1800000;
    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 16'd5000;
    localparam logic [LIMIT_W-1:0] ACTION_LIMIT_MAX = 21'd1800000;

    typedef enum logic [1:0] {
        REG_SHORT_TIMEOUT = 2'd0,
        REG_LONG_TIMEOUT  = 2'd1,
        REG_CHECK_PERIOD  = 2'd2,
        REG_FAIL_ENABLE   = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_SUSPEND_SHORT = 3'd1,
        OP_RESUME_SHORT  = 3'd2,
        OP_START         = 3'd3,
        OP_STOP          = 3'd4,
        OP_PAUSE         = 3'd5,
        OP_RESUME        = 3'd6,
        OP_STOP_MONITOR  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DEAD      = 3'd1,
        STAT_EXISTS    = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_NO_CHANGE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_PAUSED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LONG,
        ST_SHORT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: sv/boot_watchdog_with_action_timers_top.sv
`default_nettype none

// Boot watchdog with per-action timers.
// The input channel (s_valid/s_ready) carries one item per handshake: a one
// millisecond tick or a command (suspend/resume short counter, start, stop,
// pause or resume an action timer, stop monitor). Every item returns exactly
// one result item on the m_ channel: status, short counter state, monitor
// state and the fail event of a period check.
// Commands finish in the accept cycle; their result is valid in the next cycle.
// A tick that leaves the monitor alive runs the sequencer after its accept:
// one shared saturating incrementer and comparator visits the long counter, the
// short counter and then every slot of the action table, which sits in a RAM
// with a registered read port, so the read of each slot overlaps the update
// of the one before. The tick result is registered in the finish state.
// The block takes one item at a time; it is ready again in the cycle after a
// tick finishes, or right away after a command, as long as the result
// register is empty or being drained. A stalled receiver holds the result
// register and with it the input side. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata) that the user must write only while idle;
// the block itself does not enforce this. Reset restores the default limits,
// clears all counters and frees every slot; no clearing pass is needed.
module boot_watchdog_with_action_timers_top
    import bwd_pkg::*;
#(
    parameter int TIMER_SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [2:0]  s_timer_id,
    input  wire logic [31:0] s_timeout_ms,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_short_running,
    output logic             m_monitor_alive,
    output logic             m_fail_event
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam int RAM_W = COUNT_W + LIMIT_W;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  short_to_reg, long_to_reg;
    logic [PERIOD_W-1:0] period_cfg_reg;
    logic                fail_en_reg;

    logic [COUNT_W-1:0]  long_count_reg, long_count_next;
    logic [COUNT_W-1:0]  short_count_reg, short_count_next;
    logic                short_en_reg, short_en_next;
    logic                alive_reg, alive_next;
    logic                run_req_reg, run_req_next;
    logic [PERIOD_W-1:0] period_count_reg, period_count_next;
    mode_t               mode_reg [TIMER_SLOTS];
    mode_t               mode_next [TIMER_SLOTS];
    logic [CNT_W-1:0]    active_cnt_reg, active_cnt_next;

    logic                close_reg, close_next;
    logic                fail_reg, fail_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   pend_idx_reg, pend_idx_next;

    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic                m_short_running_reg, m_short_running_next;
    logic                m_monitor_alive_reg, m_monitor_alive_next;
    logic                m_fail_event_reg, m_fail_event_next;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;
    logic [COUNT_W-1:0]  rd_count;
    logic [LIMIT_W-1:0]  rd_limit;

    logic                in_acc;
    op_t                 op;
    logic                in_range;
    logic [SLOT_W-1:0]   id_idx;
    mode_t               cur_mode;
    logic [LIMIT_W-1:0]  clamp_limit;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W-1:0] pc_inc;
    logic                tick_close;
    logic                is_tick;
    logic                tick_die;
    logic                slot_active;

    // Shared saturating incrementer and comparator.
    logic [COUNT_W-1:0]  unit_src, unit_sum, unit_val, unit_lim;
    logic                unit_inc, unit_ge;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_acc = s_valid && s_ready;
    assign op = op_t'(s_op);
    assign in_range = (32'(s_timer_id) < TIMER_SLOTS);
    assign id_idx = SLOT_W'(s_timer_id);
    assign cur_mode = mode_reg[id_idx];
    assign clamp_limit = (s_timeout_ms > 32'(ACTION_LIMIT_MAX)) ?
                         ACTION_LIMIT_MAX : s_timeout_ms[LIMIT_W-1:0];

    assign period_eff = (period_cfg_reg == '0) ? PERIOD_W'(1) : period_cfg_reg;
    assign pc_inc = period_count_reg + 1'b1;
    assign tick_close = (pc_inc >= period_eff);
    assign is_tick = alive_reg && (op == OP_TICK);
    assign tick_die = is_tick && tick_close && !run_req_reg;

    assign rd_count = ram_rdata[COUNT_W-1:0];
    assign rd_limit = ram_rdata[RAM_W-1:COUNT_W];
    assign slot_active = pend_reg && (mode_reg[pend_idx_reg] == MODE_ACTIVE);

    always_comb begin
        case (state_reg)
            ST_LONG: begin
                unit_src = long_count_reg;
                unit_lim = long_to_reg;
                unit_inc = 1'b1;
            end
            ST_SHORT: begin
                unit_src = short_count_reg;
                unit_lim = short_to_reg;
                unit_inc = short_en_reg;
            end
            default: begin
                unit_src = rd_count;
                unit_lim = COUNT_W'(rd_limit);
                unit_inc = slot_active;
            end
        endcase
        unit_sum = sat_inc(unit_src);
        unit_val = unit_inc ? unit_sum : unit_src;
        unit_ge = (unit_val >= unit_lim);
    end

    bwd_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TIMER_SLOTS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(scan_idx_reg[SLOT_W-1:0]),
        .rdata(ram_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && is_tick && !tick_die) begin
                    state_next = ST_LONG;
                end
            end
            ST_LONG: state_next = ST_SHORT;
            ST_SHORT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_idx_reg == SLOTS_C && !pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb begin
        logic             load_res;
        logic [CNT_W-1:0] cnt_after;

        long_count_next = long_count_reg;
        short_count_next = short_count_reg;
        short_en_next = short_en_reg;
        alive_next = alive_reg;
        run_req_next = run_req_reg;
        period_count_next = period_count_reg;
        mode_next = mode_reg;
        active_cnt_next = active_cnt_reg;
        close_next = close_reg;
        fail_next = fail_reg;
        scan_idx_next = scan_idx_reg;
        pend_next = pend_reg;
        pend_idx_next = pend_idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_short_running_next = m_short_running_reg;
        m_monitor_alive_next = m_monitor_alive_reg;
        m_fail_event_next = m_fail_event_reg;
        ram_we = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = {rd_limit, unit_val};
        load_res = 1'b0;
        cnt_after = active_cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    load_res = 1'b1;
                    m_status_next = STAT_OK;
                    if (!alive_reg) begin
                        m_status_next = STAT_DEAD;
                    end else begin
                        case (op)
                            OP_TICK: begin
                                period_count_next = tick_close ? '0 : pc_inc;
                                close_next = tick_close;
                                if (tick_die) begin
                                    // Stop was requested: the monitor dies here.
                                    alive_next = 1'b0;
                                    active_cnt_next = '0;
                                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                                        mode_next[i] = MODE_FREE;
                                    end
                                end else begin
                                    load_res = 1'b0;
                                end
                            end
                            OP_SUSPEND_SHORT: begin
                                if (short_en_reg) begin
                                    short_en_next = 1'b0;
                                end else begin
                                    m_status_next = STAT_NO_CHANGE;
                                end
                            end
                            OP_RESUME_SHORT: begin
                                if (short_en_reg) begin
                                    m_status_next = STAT_NO_CHANGE;
                                end else begin
                                    short_en_next = 1'b1;
                                end
                            end
                            OP_START: begin
                                if (!in_range) begin
                                    m_status_next = STAT_FULL;
                                end else if (cur_mode != MODE_FREE) begin
                                    m_status_next = STAT_EXISTS;
                                end else begin
                                    mode_next[id_idx] = MODE_ACTIVE;
                                    active_cnt_next = active_cnt_reg + 1'b1;
                                    ram_we = 1'b1;
                                    ram_waddr = id_idx;
                                    ram_wdata = {clamp_limit, {COUNT_W{1'b0}}};
                                    short_en_next = 1'b0;
                                    if (!short_en_reg) begin
                                        m_status_next = STAT_NO_CHANGE;
                                    end
                                end
                            end
                            OP_STOP: begin
                                if (in_range && cur_mode != MODE_FREE) begin
                                    mode_next[id_idx] = MODE_FREE;
                                    if (cur_mode == MODE_ACTIVE) begin
                                        cnt_after = active_cnt_reg - 1'b1;
                                    end
                                end else begin
                                    m_status_next = STAT_NOT_FOUND;
                                end
                                active_cnt_next = cnt_after;
                                if (cnt_after == '0) begin
                                    short_en_next = 1'b1;
                                end
                            end
                            OP_PAUSE: begin
                                if (!in_range || cur_mode != MODE_ACTIVE) begin
                                    m_status_next = STAT_NOT_FOUND;
                                end else begin
                                    mode_next[id_idx] = MODE_PAUSED;
                                    cnt_after = active_cnt_reg - 1'b1;
                                    active_cnt_next = cnt_after;
                                    if (cnt_after == '0) begin
                                        short_en_next = 1'b1;
                                    end
                                end
                            end
                            OP_RESUME: begin
                                if (!in_range || cur_mode != MODE_PAUSED) begin
                                    m_status_next = STAT_NOT_FOUND;
                                end else begin
                                    mode_next[id_idx] = MODE_ACTIVE;
                                    active_cnt_next = active_cnt_reg + 1'b1;
                                    short_en_next = 1'b0;
                                end
                            end
                            OP_STOP_MONITOR: begin
                                run_req_next = 1'b0;
                            end
                            default: begin
                                run_req_next = 1'b0;
                            end
                        endcase
                    end
                    if (load_res) begin
                        m_valid_next = 1'b1;
                        m_short_running_next = short_en_next;
                        m_monitor_alive_next = alive_next;
                        m_fail_event_next = 1'b0;
                    end
                end
            end
            ST_LONG: begin
                long_count_next = unit_val;
                fail_next = unit_ge;
            end
            ST_SHORT: begin
                short_count_next = unit_val;
                fail_next = fail_reg || unit_ge;
                scan_idx_next = '0;
                pend_next = 1'b0;
            end
            ST_SCAN: begin
                // Read of the next slot overlaps the update of the previous one.
                if (scan_idx_reg != SLOTS_C) begin
                    pend_next = 1'b1;
                    pend_idx_next = scan_idx_reg[SLOT_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (slot_active) begin
                    ram_we = 1'b1;
                    fail_next = fail_reg || unit_ge;
                end
            end
            ST_FINISH: begin
                m_valid_next = 1'b1;
                m_status_next = STAT_OK;
                m_short_running_next = short_en_reg;
                m_monitor_alive_next = alive_reg;
                m_fail_event_next = close_reg && fail_reg && fail_en_reg;
                if (close_reg && fail_reg) begin
                    run_req_next = 1'b0;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            short_to_reg <= SHORT_TIMEOUT_RST;
            long_to_reg <= LONG_TIMEOUT_RST;
            period_cfg_reg <= CHECK_PERIOD_RST;
            fail_en_reg <= 1'b1;
            long_count_reg <= '0;
            short_count_reg <= '0;
            short_en_reg <= 1'b1;
            alive_reg <= 1'b1;
            run_req_reg <= 1'b1;
            period_count_reg <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                mode_reg[i] <= MODE_FREE;
            end
            active_cnt_reg <= '0;
            close_reg <= 1'b0;
            fail_reg <= 1'b0;
            scan_idx_reg <= '0;
            pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_SHORT_TIMEOUT: short_to_reg <= cfg_wdata;
                    REG_LONG_TIMEOUT: long_to_reg <= cfg_wdata;
                    REG_CHECK_PERIOD: period_cfg_reg <= cfg_wdata[PERIOD_W-1:0];
                    REG_FAIL_ENABLE: fail_en_reg <= cfg_wdata[0];
                    default: fail_en_reg <= fail_en_reg;
                endcase
            end
            long_count_reg <= long_count_next;
            short_count_reg <= short_count_next;
            short_en_reg <= short_en_next;
            alive_reg <= alive_next;
            run_req_reg <= run_req_next;
            period_count_reg <= period_count_next;
            mode_reg <= mode_next;
            active_cnt_reg <= active_cnt_next;
            close_reg <= close_next;
            fail_reg <= fail_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        m_status_reg <= m_status_next;
        m_short_running_reg <= m_short_running_next;
        m_monitor_alive_reg <= m_monitor_alive_next;
        m_fail_event_reg <= m_fail_event_next;
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_short_running = m_short_running_reg;
    assign m_monitor_alive = m_monitor_alive_reg;
    assign m_fail_event = m_fail_event_reg;

    a_active_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_cnt_reg <= SLOTS_C)
        else $error("active slot count exceeds the table size");

    a_dead_no_active: assert property (@(posedge aclk) disable iff (!aresetn)
        !alive_reg |-> (active_cnt_reg == '0))
        else $error("active slots left after the monitor died");

    a_dead_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        !alive_reg |=> !alive_reg)
        else $error("monitor came back to life");

    a_fail_drops_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fail_event_reg) |-> !run_req_reg)
        else $error("fail event reported without a shutdown request");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending while a tick is in work");

endmodule

`default_nettype wire

// File: sv/bwd_ram.sv
`default_nettype none

module bwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
